[src/bfbt_pkg.sv]
// Shared types and constants of the best-fit block table.
// No dependencies; every other file of the block imports this package.
package bfbt_pkg;

	localparam int OP_W     = 2;
	localparam int DATA_W   = 32;
	localparam int SIZE_W   = 32;
	localparam int IDX_W    = 6;
	localparam int STATUS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND  = 2'd0,
		OP_REQUEST = 2'd1,
		OP_LOOKUP  = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic do_append;
		logic scan_start;
		logic scan_rd;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic full;
		logic scan_last;
		logic count_zero;
		logic addr_zero;
	} dp_status_t;

endpackage

[src/bfbt_req_if.sv]
// Request channel of the best-fit block table: valid, ready and the request fields.
// Depends on bfbt_pkg for the field widths.
interface bfbt_req_if import bfbt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [DATA_W-1:0] data_addr;
	logic [SIZE_W-1:0] block_size;
	logic              entry_free;

	modport source (output valid, op, data_addr, block_size, entry_free, input ready);
	modport sink   (input valid, op, data_addr, block_size, entry_free, output ready);
endinterface

[src/bfbt_rsp_if.sv]
// Response channel of the best-fit block table: valid, ready and the result fields.
// Depends on bfbt_pkg for the field widths.
interface bfbt_rsp_if import bfbt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    entry_index;
	logic [SIZE_W-1:0]   found_size;
	logic [DATA_W-1:0]   found_addr;

	modport source (output valid, status, entry_index, found_size, found_addr, input ready);
	modport sink   (input valid, status, entry_index, found_size, found_addr, output ready);
endinterface

[src/best_fit_block_table.sv]
// Top level of the best-fit block table: joins the controller and the datapath.
// Depends on bfbt_pkg, bfbt_req_if, bfbt_rsp_if, bfbt_ctrl and bfbt_datapath.
//
//  channel  modport  fields                                      role
//  req      sink     op, data_addr, block_size, entry_free       operation to run
//  rsp      source   status, entry_index, found_size, found_addr one result per request
//
// An append, or a search with nothing to scan, goes from EXEC to FINISH and loads its
// result there; a search that scans passes through SCAN and DRAIN first, reading through
// the record memory's single read port, one record per cycle; input is ready only in IDLE.
// Reset clears counters, state and valid flags; the record memory has no clearing pass.
// The result waits in an output register; the next transaction is accepted while it
// waits and its own result is loaded once the waiting one is taken.
module best_fit_block_table import bfbt_pkg::*; #(
	parameter int ENTRIES   = 64,
	parameter int ADDR_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	bfbt_req_if.sink   req,
	bfbt_rsp_if.source rsp
);

	cmd_t       cmd;
	dp_status_t st;

	bfbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.st        (st),
		.cmd       (cmd)
	);

	bfbt_datapath #(
		.ENTRIES   (ENTRIES),
		.ADDR_BITS (ADDR_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.req_op          (req.op),
		.req_data_addr   (req.data_addr),
		.req_block_size  (req.block_size),
		.req_entry_free  (req.entry_free),
		.rsp_status      (rsp.status),
		.rsp_entry_index (rsp.entry_index),
		.rsp_found_size  (rsp.found_size),
		.rsp_found_addr  (rsp.found_addr)
	);

endmodule

[src/bfbt_datapath.sv]
// Datapath of the best-fit block table: record memory, scan counter, compare stage,
// result and output registers. Depends on bfbt_pkg; driven by bfbt_ctrl commands.
module bfbt_datapath import bfbt_pkg::*; #(
	parameter int ENTRIES   = 64,
	parameter int ADDR_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output dp_status_t          st,
	input  logic [OP_W-1:0]     req_op,
	input  logic [DATA_W-1:0]   req_data_addr,
	input  logic [SIZE_W-1:0]   req_block_size,
	input  logic                req_entry_free,
	output logic [STATUS_W-1:0] rsp_status,
	output logic [IDX_W-1:0]    rsp_entry_index,
	output logic [SIZE_W-1:0]   rsp_found_size,
	output logic [DATA_W-1:0]   rsp_found_addr
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	typedef struct packed {
		logic [ADDR_BITS-1:0] addr;
		logic [SIZE_W-1:0]    size;
		logic                 free;
	} rec_t;

	rec_t mem_q [ENTRIES];

	op_t                  op_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [SIZE_W-1:0]    size_q;
	logic                 free_q;
	logic [CW-1:0]        count_q;
	logic [IW-1:0]        rd_ctr_q;
	logic                 rd_vld_s1;
	logic [IW-1:0]        rd_idx_s1;
	rec_t                 rd_rec_s1;
	status_t              res_status_q;
	logic [IW-1:0]        res_idx_q;
	logic [SIZE_W-1:0]    res_size_q;
	logic [ADDR_BITS-1:0] res_addr_q;
	status_t              out_status_q;
	logic [IDX_W-1:0]     out_idx_q;
	logic [SIZE_W-1:0]    out_size_q;
	logic [DATA_W-1:0]    out_addr_q;

	logic full;
	logic hit_now;

	assign full = (count_q == CW'(ENTRIES));

	// A lookup keeps only the first match; a request keeps the smallest fitting
	// free record, and a later record of equal size does not replace it.
	always_comb begin
		hit_now = 1'b0;
		if (rd_vld_s1) begin
			if (op_q == OP_LOOKUP) begin
				hit_now = (rd_rec_s1.addr == addr_q) && (res_status_q != ST_OK);
			end else begin
				hit_now = rd_rec_s1.free && (rd_rec_s1.size >= size_q) &&
				          ((res_status_q != ST_OK) || (rd_rec_s1.size < res_size_q));
			end
		end
	end

	always_comb begin
		st.op         = op_q;
		st.full       = full;
		st.scan_last  = ((CW'(rd_ctr_q) + CW'(1)) == count_q);
		st.count_zero = (count_q == '0);
		st.addr_zero  = (addr_q == '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.do_append && !full) begin
			mem_q[count_q[IW-1:0]] <= '{addr: addr_q, size: size_q, free: free_q};
		end
		if (cmd.scan_rd) begin
			rd_rec_s1 <= mem_q[rd_ctr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rd_ctr_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.do_append && !full) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.scan_start) begin
				rd_ctr_q <= '0;
			end else if (cmd.scan_rd) begin
				rd_ctr_q <= rd_ctr_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			rd_idx_s1 <= rd_ctr_q;
		end
		if (cmd.accept) begin
			op_q         <= op_t'(req_op);
			addr_q       <= ADDR_BITS'(req_data_addr);
			size_q       <= req_block_size;
			free_q       <= req_entry_free;
			res_status_q <= ST_NOT_FOUND;
			res_idx_q    <= '0;
			res_size_q   <= '0;
			res_addr_q   <= '0;
		end else if (cmd.do_append) begin
			res_status_q <= full ? ST_FULL : ST_OK;
			res_idx_q    <= full ? '0 : count_q[IW-1:0];
		end else if (hit_now) begin
			res_status_q <= ST_OK;
			res_idx_q    <= rd_idx_s1;
			res_size_q   <= rd_rec_s1.size;
			res_addr_q   <= rd_rec_s1.addr;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_idx_q    <= IDX_W'(res_idx_q);
			out_size_q   <= res_size_q;
			out_addr_q   <= DATA_W'(res_addr_q);
		end
	end

	assign rsp_status      = out_status_q;
	assign rsp_entry_index = out_idx_q;
	assign rsp_found_size  = out_size_q;
	assign rsp_found_addr  = out_addr_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES))
		else $error("record count exceeds table depth");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_rd |-> (CW'(rd_ctr_q) < count_q))
		else $error("scan reads beyond the stored records");

	a_full_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.do_append && full) |=> $stable(count_q))
		else $error("append to a full table changed the count");

endmodule

[src/bfbt_ctrl.sv]
// Controller of the best-fit block table: one-hot sequencer and output valid flag.
// Depends on bfbt_pkg; issues commands to bfbt_datapath.
module bfbt_ctrl import bfbt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  dp_status_t st,
	output cmd_t       cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_EXEC   = 5'b00010,
		S_SCAN   = 5'b00100,
		S_DRAIN  = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				if (st.op == OP_APPEND) begin
					cmd.do_append = 1'b1;
					state_d       = S_FINISH;
				end else if (!st.count_zero && ((st.op == OP_REQUEST) ||
				             ((st.op == OP_LOOKUP) && !st.addr_zero))) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (st.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// The last record read is compared in this cycle.
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> out_free)
		else $error("result overwrote a transaction not yet taken");

	a_scan_then_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && st.scan_last) |=> (state_q == S_DRAIN))
		else $error("scan did not stop after the last record");

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("result dropped before it was taken");

endmodule
